// File: hdl/ste_pkg.sv
// Shared types and codes for the sorted table engine.
package ste_pkg;

  typedef logic signed [31:0] value_t;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 88;

endpackage

// File: hdl/sorted_table_engine.sv
// Sorted table engine: ascending signed table in a single-port RAM.
// Insert: from the top, each entry larger than the value moves up one place (read, then write),
// and the value lands where this stops. Search/delete scan up from position 1; delete then moves
// later entries down. Each op ends in min/max readback; full insert and clear go straight there.
// Result waits in an output register; the next transfer is taken in the cycle after it loads.
// rst_n (sync, active low) empties the table and clears control; RAM contents are not cleared.
module sorted_table_engine
  import ste_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] operation, [33:2] value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [1:0] status, [2] found, [9:3] position,
                                             // [16:10] entry_count, [48:17] smallest,
                                             // [80:49] largest
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_RD   = 4'd1;
  localparam logic [3:0] S_INS_WR   = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CMP = 4'd4;
  localparam logic [3:0] S_DEL_RD   = 4'd5;
  localparam logic [3:0] S_DEL_WR   = 4'd6;
  localparam logic [3:0] S_FIN_A    = 4'd7;
  localparam logic [3:0] S_FIN_B    = 4'd8;
  localparam logic [3:0] S_FIN_C    = 4'd9;

  // table storage
  value_t mem [CAPACITY];
  value_t rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  value_t        wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [1:0]       op_r, op_nxt;
  value_t           val_r, val_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  value_t           min_r, min_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             o_status_r, o_status_nxt;
  logic                   o_found_r, o_found_nxt;
  logic [6:0]             o_pos_r, o_pos_nxt;
  logic [6:0]             o_cnt_r, o_cnt_nxt;
  value_t                 o_min_r, o_min_nxt;
  value_t                 o_max_r, o_max_nxt;

  logic [CNT_W-1:0] idx_m1, idx_p1, cnt_m1;
  logic [CNT_W+6:0] pos_ext, cnt_ext;
  logic             in_xfer;
  logic             out_free;

  assign idx_m1   = idx_r - ONE_C;
  assign idx_p1   = idx_r + ONE_C;
  assign cnt_m1   = cnt_r - ONE_C;
  assign pos_ext  = {7'd0, pos_r};
  assign cnt_ext  = {7'd0, cnt_r};
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    st_nxt        = st_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_status_nxt  = o_status_r;
    o_found_nxt   = o_found_r;
    o_pos_nxt     = o_pos_r;
    o_cnt_nxt     = o_cnt_r;
    o_min_nxt     = o_min_r;
    o_max_nxt     = o_max_r;
    rd_addr       = idx_r[AW-1:0];
    we            = 1'b0;
    wa            = idx_r[AW-1:0];
    wd            = val_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_tdata[1:0];
          val_nxt   = in_tdata[33:2];
          st_nxt    = ST_DONE;
          found_nxt = 1'b0;
          pos_nxt   = '0;
          case (in_tdata[1:0])
            OP_INSERT: begin
              idx_nxt = cnt_r;
              if (cnt_r >= CAP_C) begin
                st_nxt    = ST_FULL;
                state_nxt = S_FIN_A;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            OP_DELETE, OP_SEARCH: begin
              idx_nxt   = '0;
              state_nxt = S_SCAN_RD;
            end
            default: begin
              cnt_nxt   = '0;
              state_nxt = S_FIN_A;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          cnt_nxt   = cnt_r + ONE_C;
          state_nxt = S_FIN_A;
        end else begin
          rd_addr   = idx_m1[AW-1:0];
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        we = 1'b1;
        // larger neighbor moves up; equal ones stay below the new value
        if (rd_data_r > val_r) begin
          wd        = rd_data_r;
          idx_nxt   = idx_m1;
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + ONE_C;
          state_nxt = S_FIN_A;
        end
      end
      S_SCAN_RD: begin
        if (idx_r >= cnt_r) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_FIN_A;
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (rd_data_r == val_r) begin
          found_nxt = 1'b1;
          if (op_r == OP_SEARCH) begin
            pos_nxt   = idx_p1;
            state_nxt = S_FIN_A;
          end else begin
            state_nxt = S_DEL_RD;
          end
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_DEL_RD: begin
        rd_addr = idx_p1[AW-1:0];
        if (idx_p1 >= cnt_r) begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_FIN_A;
        end else begin
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        we        = 1'b1;
        wd        = rd_data_r;
        idx_nxt   = idx_p1;
        state_nxt = S_DEL_RD;
      end
      S_FIN_A: begin
        rd_addr   = '0;
        state_nxt = S_FIN_B;
      end
      S_FIN_B: begin
        min_nxt   = rd_data_r;
        rd_addr   = cnt_m1[AW-1:0];
        state_nxt = S_FIN_C;
      end
      S_FIN_C: begin
        rd_addr = cnt_m1[AW-1:0];
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = st_r;
          o_found_nxt   = found_r;
          o_pos_nxt     = pos_ext[6:0];
          o_cnt_nxt     = cnt_ext[6:0];
          o_min_nxt     = (cnt_r == '0) ? '0 : min_r;
          o_max_nxt     = (cnt_r == '0) ? '0 : rd_data_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    st_r       <= st_nxt;
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    min_r      <= min_nxt;
    o_status_r <= o_status_nxt;
    o_found_r  <= o_found_nxt;
    o_pos_r    <= o_pos_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_min_r    <= o_min_nxt;
    o_max_r    <= o_max_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, o_max_r, o_min_r, o_cnt_r, o_pos_r, o_found_r, o_status_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("entry count above capacity");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_found_r |-> o_status_r == ST_DONE)
    else $error("found result with error status");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_cnt_r == 7'd0 && CAPACITY < 128 |-> o_min_r == '0 && o_max_r == '0)
    else $error("empty table reports nonzero min/max");

  a_pos_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_pos_r != 7'd0 |-> o_found_r)
    else $error("position reported without a match");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("engine idle right after a transfer");

endmodule
